### sv/filled_circle_span_generator_top_defines.svh
// ============================================================================
// Assertion macros for the filled circle span generator
// Shared property forms used by the port checker.
// ============================================================================
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_TOP_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, idle during reset
`define FCSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define FCSG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// same-cycle implication, checked through reset as well
`define FCSG_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/fcsg_pkg.sv
// ============================================================================
// fcsg_pkg
// Types, constants and small tables of the filled circle span generator.
// ============================================================================
`default_nettype none

package fcsg_pkg;

    localparam logic [3:0]  MAX_RADIUS   = 4'd15;
    localparam int          QUEUE_DEPTH  = 2;

    localparam int          CFG_INDEX_W  = 1;
    localparam int          CFG_DATA_W   = 12;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  SCREEN_WIDTH_RST  = 12'd320;
    localparam logic [CFG_DATA_W-1:0]  SCREEN_HEIGHT_RST = 12'd480;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [3:0]  radius;
        logic [15:0] fill_color;
    } t_circle_req;

    typedef struct packed {
        logic [15:0] span_x;
        logic [15:0] span_y;
        logic [4:0]  span_len;
        logic [15:0] span_color;
        logic        last_span;
    } t_span;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [3:0]  radius;
        logic [15:0] fill_color;
        logic [3:0]  imax;
        logic [7:0]  sqmax;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // floor(r * 707 / 1000) + 1
    function automatic logic [3:0] imax_of(input logic [3:0] r);
        logic [3:0] v;
        unique case (r)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd0;
            4'd2:    v = 4'd1;
            4'd3:    v = 4'd2;
            4'd4:    v = 4'd2;
            4'd5:    v = 4'd3;
            4'd6:    v = 4'd4;
            4'd7:    v = 4'd4;
            4'd8:    v = 4'd5;
            4'd9:    v = 4'd6;
            4'd10:   v = 4'd7;
            4'd11:   v = 4'd7;
            4'd12:   v = 4'd8;
            4'd13:   v = 4'd9;
            4'd14:   v = 4'd9;
            default: v = 4'd10;
        endcase
        return v + 4'd1;
    endfunction

    // r * r + r / 2
    function automatic logic [7:0] sqmax_of(input logic [3:0] r);
        logic [7:0] sq;
        sq = {4'b0, r} * {4'b0, r};
        return sq + {5'b0, r[3:1]};
    endfunction

endpackage

`default_nettype wire

### sv/fcsg_front.sv
// ============================================================================
// fcsg_front
// Accepts circle requests, drops empty radii and precomputes loop bounds.
// ============================================================================
`default_nettype none

module fcsg_front (
    input  wire logic                 i_in_valid,
    input  fcsg_pkg::t_circle_req     i_in_data,
    output logic                      o_in_ready,
    input  fcsg_pkg::t_q_stat         i_q_stat,
    output logic                      o_push,
    output fcsg_pkg::t_job            o_job
);
    import fcsg_pkg::*;

    logic w_radius_ok;

    assign w_radius_ok = (i_in_data.radius != 4'd0) && (i_in_data.radius <= MAX_RADIUS);
    assign o_in_ready  = !i_q_stat.full;
    assign o_push      = i_in_valid && o_in_ready && w_radius_ok;

    always_comb begin
        o_job.center_x   = i_in_data.center_x;
        o_job.center_y   = i_in_data.center_y;
        o_job.radius     = i_in_data.radius;
        o_job.fill_color = i_in_data.fill_color;
        o_job.imax       = imax_of(i_in_data.radius);
        o_job.sqmax      = sqmax_of(i_in_data.radius);
    end

endmodule

`default_nettype wire

### sv/fcsg_queue.sv
// ============================================================================
// fcsg_queue
// Small job FIFO between the request front and the span sequencer.
// ============================================================================
`default_nettype none

module fcsg_queue #(
    parameter int P_DEPTH = fcsg_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  fcsg_pkg::t_job     i_push_data,
    input  wire logic          i_pop,
    output fcsg_pkg::t_job     o_head,
    output fcsg_pkg::t_q_stat  o_stat
);
    import fcsg_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_job           r_mem [P_DEPTH];
    logic [AW-1:0]  r_wr, n_wr;
    logic [AW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;
    logic           w_push, w_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + AW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + AW'(1);
        end
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### sv/fcsg_back.sv
// ============================================================================
// fcsg_back
// Span sequencer: walks the midpoint rows, clips spans, holds one span
// back to mark the last one, and drives the output register.
// ============================================================================
`default_nettype none

module fcsg_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [fcsg_pkg::CFG_DATA_W-1:0]    i_screen_width,
    input  wire logic [fcsg_pkg::CFG_DATA_W-1:0]    i_screen_height,
    input  fcsg_pkg::t_q_stat                       i_q_stat,
    input  fcsg_pkg::t_job                          i_head,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output fcsg_pkg::t_span                         o_out_data
);
    import fcsg_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CENTER = 3'd1;
    localparam logic [2:0] ST_OUT_A  = 3'd2;
    localparam logic [2:0] ST_OUT_B  = 3'd3;
    localparam logic [2:0] ST_IN_A   = 3'd4;
    localparam logic [2:0] ST_IN_B   = 3'd5;
    localparam logic [2:0] ST_FLUSH  = 3'd6;

    logic [2:0]  r_state, n_state;
    t_job        r_job, n_job;
    logic [3:0]  r_i, n_i;
    logic [3:0]  r_x, n_x;
    logic        r_pend_valid, n_pend_valid;
    t_span       r_pend, n_pend;
    logic        r_out_valid, n_out_valid;
    t_span       r_out, n_out;

    logic        w_adv;
    logic [7:0]  w_ii, w_xx;
    logic        w_shrink;
    logic        w_outer;
    logic [3:0]  w_x_dec;
    logic [3:0]  w_im1;
    logic        c_emit;
    logic [15:0] c_x, c_y;
    logic [4:0]  c_len;
    t_span       w_cand;

    function automatic t_span clip_span(
        input t_span                 s,
        input logic [CFG_DATA_W-1:0] w,
        input logic [CFG_DATA_W-1:0] h
    );
        t_span       o;
        logic [16:0] x_end;
        o     = s;
        x_end = {1'b0, s.span_x} + {12'b0, s.span_len} - 17'd1;
        if (x_end >= {5'b0, w}) begin
            o.span_x = {4'b0, w} - {11'b0, s.span_len} - 16'd1;
        end
        if (s.span_y >= {4'b0, h}) begin
            o.span_y = {4'b0, h} - 16'd1;
        end
        return o;
    endfunction

    assign w_adv    = !r_out_valid || i_out_ready;
    assign w_ii     = {4'b0, r_i} * {4'b0, r_i};
    assign w_xx     = {4'b0, r_x} * {4'b0, r_x};
    assign w_shrink = ({1'b0, w_ii} + {1'b0, w_xx}) > {1'b0, r_job.sqmax};
    assign w_outer  = w_shrink && (r_x > r_job.imax);
    assign w_x_dec  = (w_shrink && (r_x != 4'd0)) ? r_x - 4'd1 : r_x;
    assign w_im1    = r_i - 4'd1;

    always_comb begin
        c_emit = 1'b0;
        c_x    = r_job.center_x;
        c_y    = r_job.center_y;
        c_len  = 5'd0;
        unique case (r_state)
            ST_CENTER: begin
                c_emit = 1'b1;
                c_x    = r_job.center_x - {12'b0, r_job.radius};
                c_len  = {r_job.radius, 1'b0};
            end
            ST_OUT_A: begin
                c_emit = 1'b1;
                if (w_outer) begin
                    c_x   = r_job.center_x - {12'b0, w_im1};
                    c_y   = r_job.center_y + {12'b0, r_x};
                    c_len = {w_im1, 1'b0};
                end else begin
                    c_x   = r_job.center_x - {12'b0, w_x_dec};
                    c_y   = r_job.center_y + {12'b0, r_i};
                    c_len = {w_x_dec, 1'b0};
                end
            end
            ST_OUT_B: begin
                c_emit = 1'b1;
                c_x    = r_job.center_x - {12'b0, w_im1};
                c_y    = r_job.center_y - {12'b0, r_x};
                c_len  = {w_im1, 1'b0};
            end
            ST_IN_A: begin
                c_emit = 1'b1;
                c_x    = r_job.center_x - {12'b0, r_x};
                c_y    = r_job.center_y + {12'b0, r_i};
                c_len  = {r_x, 1'b0};
            end
            ST_IN_B: begin
                c_emit = 1'b1;
                c_x    = r_job.center_x - {12'b0, r_x};
                c_y    = r_job.center_y - {12'b0, r_i};
                c_len  = {r_x, 1'b0};
            end
            default: begin
                c_emit = 1'b0;
            end
        endcase
        w_cand = clip_span(t_span'{span_x:     c_x,
                                   span_y:     c_y,
                                   span_len:   c_len,
                                   span_color: r_job.fill_color,
                                   last_span:  1'b0},
                           i_screen_width, i_screen_height);
    end

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_i          = r_i;
        n_x          = r_x;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        o_pop        = 1'b0;
        if (r_state == ST_IDLE) begin
            if (!i_q_stat.empty) begin
                o_pop   = 1'b1;
                n_job   = i_head;
                n_state = ST_CENTER;
            end
        end else if (w_adv) begin
            if (c_emit && (c_len != 5'd0)) begin
                if (r_pend_valid) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                end
                n_pend       = w_cand;
                n_pend_valid = 1'b1;
            end
            unique case (r_state)
                ST_CENTER: begin
                    n_i     = 4'd1;
                    n_x     = r_job.radius;
                    n_state = ST_OUT_A;
                end
                ST_OUT_A: begin
                    priority if (w_outer) begin
                        n_state = ST_OUT_B;
                    end else begin
                        n_x     = w_x_dec;
                        n_state = ST_IN_B;
                    end
                end
                ST_OUT_B: begin
                    n_x     = w_x_dec;
                    n_state = ST_IN_A;
                end
                ST_IN_A: begin
                    n_state = ST_IN_B;
                end
                ST_IN_B: begin
                    if (r_i == r_job.imax) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_i     = r_i + 4'd1;
                        n_state = ST_OUT_A;
                    end
                end
                ST_FLUSH: begin
                    if (r_pend_valid) begin
                        n_out           = r_pend;
                        n_out.last_span = 1'b1;
                        n_out_valid     = 1'b1;
                        n_pend_valid    = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_i    <= n_i;
        r_x    <= n_x;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### sv/filled_circle_span_generator_top.sv
// ============================================================================
// filled_circle_span_generator_top
// Turns filled-circle requests into clipped horizontal spans.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one circle per
//   beat: centre, radius 1..15 and colour. A radius of zero is taken and
//   dropped without any span.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives one span
//   per beat; last_span marks the final span of each circle.
//   Configuration: i_cfg_we writes i_cfg_data to screen width (index 0) or
//   screen height (index 1); write only while the block is idle.
// Flow:
//   Requests wait in a small job queue; the span sequencer takes one job
//   at a time and forms a candidate span in each state from CENTER to IN_B
//   while the output can advance. A span passes from the pending register
//   to the output register. One span is held back to tag the last one.
// Reset and stall:
//   Reset empties the queue and output and restores width 320, height 480.
//   A stalled receiver freezes the sequencer once it holds a job; the queue
//   keeps taking requests until it is full.
// ============================================================================
`default_nettype none

module filled_circle_span_generator_top #(
    parameter int P_QUEUE_DEPTH = fcsg_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fcsg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [fcsg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  fcsg_pkg::t_circle_req                   i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output fcsg_pkg::t_span                         o_out_data
);
    import fcsg_pkg::*;

    logic [CFG_DATA_W-1:0] r_screen_width;
    logic [CFG_DATA_W-1:0] r_screen_height;
    t_q_stat               w_q_stat;
    t_job                  w_push_job;
    t_job                  w_head;
    logic                  w_push;
    logic                  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fcsg_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    fcsg_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_job),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    fcsg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_q_stat        (w_q_stat),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data)
    );

endmodule

`default_nettype wire

### sv/fcsg_checker.sv
// ============================================================================
// fcsg_checker
// Port-level checks of the span generator, bound to the top level.
// ============================================================================
`default_nettype none

`include "filled_circle_span_generator_top_defines.svh"

module fcsg_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [fcsg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [fcsg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire logic                               o_in_ready,
    input  fcsg_pkg::t_circle_req                   i_in_data,
    input  wire logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    input  fcsg_pkg::t_span                         o_out_data
);
    import fcsg_pkg::*;

    logic w_unused;

    assign w_unused = i_cfg_we ^ (^i_cfg_index) ^ (^i_cfg_data) ^ i_in_valid ^ o_in_ready
                      ^ (^i_in_data);

    `FCSG_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "output beat changed while stalled")

    `FCSG_ASSERT_NOW(a_len_range, o_out_valid,
        (o_out_data.span_len != 5'd0) && (o_out_data.span_len <= 5'd30),
        "span length out of range")

    `FCSG_ASSERT_NOW(a_len_even, o_out_valid, !o_out_data.span_len[0],
        "span length is odd")

    `FCSG_ASSERT_ALWAYS(a_reset_idle, i_rst_n && $past(!i_rst_n), !o_out_valid,
        "output valid right after reset")

endmodule

bind filled_circle_span_generator_top fcsg_checker u_fcsg_checker (.*);

`default_nettype wire
